FILE: rtl/mmr_pkg.sv
// package of shared constants for the modexp / miller-rabin block
`default_nettype none
package mmr_pkg;
  localparam int WORD_BITS_DEF = 64;
  localparam logic MODE_POW = 1'b0;
  localparam logic MODE_MR  = 1'b1;
endpackage
`default_nettype wire

FILE: rtl/mmr_if.sv
// interfaces: request and result channels
`default_nettype none
interface mmr_req_if #(parameter int WORD_BITS = mmr_pkg::WORD_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic                 mode;
  logic [WORD_BITS-1:0] base;
  logic [WORD_BITS-1:0] exponent;
  logic [WORD_BITS-1:0] modulus;
  modport source (output valid, mode, base, exponent, modulus, input ready);
  modport sink (input valid, mode, base, exponent, modulus, output ready);
endinterface

interface mmr_rsp_if #(parameter int WORD_BITS = mmr_pkg::WORD_BITS_DEF);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] value;
  logic                 probably_prime;
  modport source (output valid, value, probably_prime, input ready);
  modport sink (input valid, value, probably_prime, output ready);
endinterface
`default_nettype wire

FILE: rtl/mmr_mulmod.sv
// shift-add modular multiplier, one bit of b per cycle
`default_nettype none
module mmr_mulmod #(
  parameter int WORD_BITS = mmr_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] a,
  input  wire logic [WORD_BITS-1:0] b,
  input  wire logic [WORD_BITS-1:0] m,
  output logic                      done,
  output logic [WORD_BITS-1:0]      prod
);
  localparam int CW = $clog2(WORD_BITS + 1);
  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] acc, acc_next, dbl, bsh;
  logic [WORD_BITS:0]   s1, s2;

  // operands a < m assumed; doubling then optional add, each reduced once
  always_comb begin
    s1 = {acc, 1'b0};
    dbl = (s1 >= {1'b0, m}) ? s1[WORD_BITS-1:0] - m : s1[WORD_BITS-1:0];
    s2 = {1'b0, dbl} + {1'b0, a};
    if (bsh[WORD_BITS-1]) begin
      acc_next = (s2 >= {1'b0, m}) ? s2[WORD_BITS-1:0] - m : s2[WORD_BITS-1:0];
    end else begin
      acc_next = dbl;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_BITS);
        acc  <= '0;
        bsh  <= b;
      end else if (busy) begin
        acc <= acc_next;
        bsh <= {bsh[WORD_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
  assign prod = acc;
endmodule
`default_nettype wire

FILE: rtl/mmr_reduce.sv
// bit-serial remainder of a word by the modulus
`default_nettype none
module mmr_reduce #(
  parameter int WORD_BITS = mmr_pkg::WORD_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [WORD_BITS-1:0] x,
  input  wire logic [WORD_BITS-1:0] m,
  output logic                      done,
  output logic [WORD_BITS-1:0]      rem
);
  localparam int CW = $clog2(WORD_BITS + 1);
  logic                 busy;
  logic [CW-1:0]        cnt;
  logic [WORD_BITS-1:0] xs;
  logic [WORD_BITS:0]   t;

  assign t = {rem, xs[WORD_BITS-1]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(WORD_BITS);
        rem  <= '0;
        xs   <= x;
      end else if (busy) begin
        rem <= (t >= {1'b0, m}) ? WORD_BITS'(t - {1'b0, m}) : t[WORD_BITS-1:0];
        xs  <= {xs[WORD_BITS-2:0], 1'b0};
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule
`default_nettype wire

FILE: rtl/modexp_miller_rabin_round.sv
// top level: modular exponentiation and one miller-rabin witness round
//
// one request word in on req, one result word out on rsp per request.
// mode 0 returns base^exponent mod modulus (0 for a zero modulus) with
// probably_prime 0; mode 1 tests modulus as candidate with base as witness
// and returns value 0 with the probably_prime flag.
// the block takes one request at a time: req.ready is high only when idle
// and no result is pending. a request first reduces the base, then for
// each exponent bit runs up to two modular products; the witness round
// adds up to r-1 squarings. every product runs on the shared shift-add
// multiplier. small and even candidates skip the arithmetic and go
// straight to the result.
// the result is held in an output register until rsp.ready; a stalled
// receiver only delays the next request. rst clears the sequencer and
// drops any request in flight.
`default_nettype none
module modexp_miller_rabin_round #(
  parameter int WORD_BITS = mmr_pkg::WORD_BITS_DEF
) (
  input wire logic clk,
  input wire logic rst,
  mmr_req_if.sink  req,
  mmr_rsp_if.source rsp
);
  localparam int RW = $clog2(WORD_BITS + 1);
  localparam logic [3:0] S_IDLE = 4'd0, S_RED = 4'd1, S_RWAIT = 4'd2,
    S_BIT = 4'd3, S_MUL = 4'd4, S_MWAIT = 4'd5, S_SQ = 4'd6, S_SWAIT = 4'd7,
    S_CHK = 4'd8, S_LOOP = 4'd9, S_LWAIT = 4'd10, S_OUT = 4'd11;

  logic [3:0]           state;
  logic                 mode;
  logic [WORD_BITS-1:0] b, e, m, acc, nm1;
  logic [RW-1:0]        r, j;
  logic                 mstart, mbusy;
  logic                 mdone, rdone, rstart;
  logic [WORD_BITS-1:0] ma, mb, prod, rem;
  logic [WORD_BITS-1:0] dval;
  logic [RW-1:0]        rcnt;

  // n-1 = 2^r * d via trailing-zero count
  always_comb begin
    rcnt = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (nm1[i]) rcnt = RW'(i);
    end
    dval = nm1 >> rcnt;
  end

  mmr_mulmod #(.WORD_BITS(WORD_BITS)) u_mul (
    .clk(clk), .rst(rst), .start(mstart), .a(ma), .b(mb), .m(m),
    .done(mdone), .prod(prod));
  mmr_reduce #(.WORD_BITS(WORD_BITS)) u_red (
    .clk(clk), .rst(rst), .start(rstart), .x(b), .m(m), .done(rdone), .rem(rem));

  assign req.ready = (state == S_IDLE);
  assign rsp.valid = (state == S_OUT);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      mstart   <= 1'b0;
      rstart   <= 1'b0;
    end else begin
      mstart   <= 1'b0;
      rstart   <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode <= req.mode;
            b    <= req.base;
            m    <= req.modulus;
            nm1  <= req.modulus - WORD_BITS'(1);
            e    <= req.exponent;
            rsp.value <= '0;
            rsp.probably_prime <= 1'b0;
            if (req.mode == mmr_pkg::MODE_POW) begin
              if (req.modulus == '0) begin
                state <= S_OUT;
              end else begin
                rstart <= 1'b1;
                state  <= S_RED;
              end
            end else if (req.modulus < WORD_BITS'(2) || !req.modulus[0]) begin
              rsp.probably_prime <= (req.modulus == WORD_BITS'(2));
              state <= S_OUT;
            end else if (req.modulus < WORD_BITS'(4)) begin
              rsp.probably_prime <= 1'b1;
              state <= S_OUT;
            end else begin
              rstart <= 1'b1;
              state  <= S_RED;
            end
          end
        end
        S_RED: state <= S_RWAIT;
        S_RWAIT: begin
          if (rdone) begin
            b   <= rem;
            acc <= (m == WORD_BITS'(1)) ? '0 : WORD_BITS'(1);
            if (mode == mmr_pkg::MODE_MR) begin
              e <= dval;
              r <= rcnt;
            end
            state <= S_BIT;
          end
        end
        S_BIT: begin
          if (e == '0) begin
            if (mode == mmr_pkg::MODE_POW) begin
              rsp.value <= acc;
              state <= S_OUT;
            end else begin
              state <= S_CHK;
            end
          end else if (e[0]) begin
            ma <= acc; mb <= b; mstart <= 1'b1;
            state <= S_MUL;
          end else begin
            state <= S_SQ;
          end
        end
        S_MUL: state <= S_MWAIT;
        S_MWAIT: if (mdone) begin
          acc <= prod;
          state <= S_SQ;
        end
        S_SQ: begin
          ma <= b; mb <= b; mstart <= 1'b1;
          e <= e >> 1;
          state <= S_SWAIT;
        end
        S_SWAIT: if (mdone && !mstart) begin
          b <= prod;
          state <= S_BIT;
        end
        S_CHK: begin
          if (acc == WORD_BITS'(1) || acc == nm1) begin
            rsp.probably_prime <= 1'b1;
            state <= S_OUT;
          end else begin
            j <= RW'(1);
            state <= S_LOOP;
          end
        end
        S_LOOP: begin
          if (j >= r) begin
            state <= S_OUT;
          end else begin
            ma <= acc; mb <= acc; mstart <= 1'b1;
            state <= S_LWAIT;
          end
        end
        S_LWAIT: if (mdone && !mstart) begin
          acc <= prod;
          j <= j + RW'(1);
          if (prod == nm1) begin
            rsp.probably_prime <= 1'b1;
            state <= S_OUT;
          end else begin
            state <= S_LOOP;
          end
        end
        S_OUT: if (rsp.ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  assign mbusy = (state == S_MWAIT) || (state == S_SWAIT) || (state == S_LWAIT);

`ifndef SYNTH
  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    mbusy |-> !req.ready) else $error("ready while multiplying");
  a_pow_flag: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && mode == mmr_pkg::MODE_POW |-> !rsp.probably_prime)
    else $error("flag set in exponent mode");
  a_mr_value: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && mode == mmr_pkg::MODE_MR |-> rsp.value == '0)
    else $error("value set in witness mode");
`endif
endmodule
`default_nettype wire

FILE: tb/tb_modexp_miller_rabin_round.sv
// testbench: modexp / miller-rabin block checked against a built-in predictor
`timescale 1ns / 100ps
`default_nettype none
module tb_modexp_miller_rabin_round;

  localparam int W = mmr_pkg::WORD_BITS_DEF;
  localparam longint unsigned CYCLE_LIMIT = 40_000_000;

  typedef struct {
    logic [W-1:0] value;
    logic         probably_prime;
  } result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mmr_req_if #(.WORD_BITS(W)) req_ch ();
  mmr_rsp_if #(.WORD_BITS(W)) rsp_ch ();

  modexp_miller_rabin_round #(.WORD_BITS(W)) dut (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch)
  );

  result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned words_sent = 0;
  int unsigned words_checked = 0;
  int unsigned sender_idle_pct = 0;
  int unsigned stall_pct = 0;
  int unsigned hold_off = 0;
  longint unsigned cycles = 0;

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor
  function automatic logic [W-1:0] prod_mod(logic [W-1:0] a, logic [W-1:0] b,
                                            logic [W-1:0] m);
    logic [2*W-1:0] p;
    p = {{W{1'b0}}, a} * {{W{1'b0}}, b};
    return W'(p % {{W{1'b0}}, m});
  endfunction

  function automatic logic [W-1:0] power_mod(logic [W-1:0] b, logic [W-1:0] e,
                                             logic [W-1:0] m);
    logic [W-1:0] acc;
    logic [W-1:0] sq;
    if (m == 0) return '0;
    acc = (m == 1) ? '0 : W'(1);
    sq = b % m;
    while (e != 0) begin
      if (e[0]) acc = prod_mod(acc, sq, m);
      e = e >> 1;
      sq = prod_mod(sq, sq, m);
    end
    return acc;
  endfunction

  function automatic logic witness_passes(logic [W-1:0] a, logic [W-1:0] n);
    logic [W-1:0] nm1;
    logic [W-1:0] d;
    logic [W-1:0] x;
    int r;
    if (n < 2) return 1'b0;
    if (n == 2) return 1'b1;
    if (!n[0]) return 1'b0;
    if (n < 4) return 1'b1;
    nm1 = n - 1;
    d = nm1;
    r = 0;
    while (!d[0]) begin
      d = d >> 1;
      r++;
    end
    x = power_mod(a, d, n);
    if (x == 1 || x == nm1) return 1'b1;
    for (int j = 1; j < r; j++) begin
      x = prod_mod(x, x, n);
      if (x == nm1) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [W-1:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  task automatic report_mismatch(string what, logic [W-1:0] got, logic [W-1:0] want);
    mismatches++;
    $display("MISMATCH %s: got %h want %h (result %0d)", what, got, want, words_checked);
  endtask

  // sender: one request word
  task automatic send_word(logic md, logic [W-1:0] b, logic [W-1:0] e, logic [W-1:0] m);
    result_t r;
    @(negedge clk);
    if ($urandom_range(99) < sender_idle_pct) begin
      req_ch.valid = 1'b0;
      repeat ($urandom_range(1, 40)) @(negedge clk);
    end
    req_ch.mode = md;
    req_ch.base = b;
    req_ch.exponent = e;
    req_ch.modulus = m;
    req_ch.valid = 1'b1;
    do @(posedge clk); while (!req_ch.ready);
    r.value = (md == mmr_pkg::MODE_POW) ? power_mod(b, e, m) : '0;
    r.probably_prime = (md == mmr_pkg::MODE_MR) ? witness_passes(b, m) : 1'b0;
    pending_results.push_back(r);
    words_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // receiver
  always @(negedge clk) begin
    if (hold_off != 0) begin
      hold_off <= hold_off - 1;
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected word", rsp_ch.value, '0);
      end else begin
        result_t want;
        want = pending_results.pop_front();
        if (rsp_ch.value !== want.value)
          report_mismatch("value", rsp_ch.value, want.value);
        if (rsp_ch.probably_prime !== want.probably_prime)
          report_mismatch("probably_prime", W'(rsp_ch.probably_prime),
                          W'(want.probably_prime));
      end
      words_checked++;
    end
  end

  initial begin
    wait (cycles >= CYCLE_LIMIT);
    $display("timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

  task automatic test_pow_directed();
    send_word(mmr_pkg::MODE_POW, 64'd5, 64'd3, 64'd0);
    send_word(mmr_pkg::MODE_POW, 64'd12345, 64'd77, 64'd1);
    send_word(mmr_pkg::MODE_POW, 64'd9, 64'd0, 64'd7);
    send_word(mmr_pkg::MODE_POW, 64'd0, 64'd0, 64'd13);
    send_word(mmr_pkg::MODE_POW, 64'd0, 64'd5, 64'd13);
    send_word(mmr_pkg::MODE_POW, '1, '1, '1);
    send_word(mmr_pkg::MODE_POW, '1, '1, 64'hffff_ffff_ffff_ffc5);
    send_word(mmr_pkg::MODE_POW, 64'd4, 64'd13, 64'd497);
    send_word(mmr_pkg::MODE_POW, 64'hdead_beef_0000_0001, 64'h8000_0000_0000_0000,
              64'd3);
  endtask

  task automatic test_witness_directed();
    send_word(mmr_pkg::MODE_MR, 64'd2, '1, 64'd0);
    send_word(mmr_pkg::MODE_MR, 64'd2, 64'd0, 64'd1);
    send_word(mmr_pkg::MODE_MR, 64'd5, 64'd0, 64'd2);
    send_word(mmr_pkg::MODE_MR, 64'd5, 64'd0, 64'd3);
    send_word(mmr_pkg::MODE_MR, 64'd3, 64'd0, 64'd4);
    send_word(mmr_pkg::MODE_MR, 64'd3, 64'd0, 64'hffff_ffff_ffff_fffe);
    send_word(mmr_pkg::MODE_MR, 64'd2, 64'd0, 64'd97);
    send_word(mmr_pkg::MODE_MR, 64'd2, 64'd0, 64'd561);
    send_word(mmr_pkg::MODE_MR, 64'd97, 64'd0, 64'd97);
    send_word(mmr_pkg::MODE_MR, 64'd98, 64'd0, 64'd97);
    send_word(mmr_pkg::MODE_MR, 64'd96, 64'd0, 64'd97);
    send_word(mmr_pkg::MODE_MR, '1, 64'd0, 64'hffff_ffff_ffff_ffc5);
    send_word(mmr_pkg::MODE_MR, 64'd2, 64'd0, '1);
    send_word(mmr_pkg::MODE_MR, 64'd2, 64'd0, 64'd2047);
  endtask

  task automatic test_random(int n);
    logic [W-1:0] primes[4] = '{64'd1000000007, 64'd4294967291,
                                64'hffff_ffff_ffff_ffc5, 64'd2305843009213693951};
    logic [W-1:0] b, e, m;
    for (int i = 0; i < n; i++) begin
      b = rand_word();
      e = rand_word();
      m = rand_word() >> $urandom_range(0, 63);
      if ($urandom_range(1)) begin
        if ($urandom_range(9) < 9) e = e >> $urandom_range(20, 63);
        if ($urandom_range(19) == 0) m = rand_word() & 64'h1f;
        send_word(mmr_pkg::MODE_POW, b, e, m);
      end else begin
        case ($urandom_range(9))
          0, 1, 2, 3: m = primes[$urandom_range(3)];
          4:          m = rand_word() & 64'h3f;
          default:    m = m | 64'd1;
        endcase
        if (m > 4 && $urandom_range(9) != 0) b = (b % (m - 3)) + 2;
        send_word(mmr_pkg::MODE_MR, b, e, m);
      end
    end
  endtask

  task automatic test_long_stall();
    hold_off = 30000;
    test_random(4);
  endtask

  initial begin
    req_ch.valid = 1'b0;
    req_ch.mode = mmr_pkg::MODE_POW;
    req_ch.base = '0;
    req_ch.exponent = '0;
    req_ch.modulus = '0;
    rsp_ch.ready = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_pow_directed();
    test_witness_directed();
    drain();
    test_random(10);
    sender_idle_pct = 76;
    test_random(20);
    drain();
    sender_idle_pct = 0;
    stall_pct = 76;
    test_random(20);
    sender_idle_pct = 11;
    stall_pct = 11;
    test_random(20);
    sender_idle_pct = 0;
    stall_pct = 0;
    test_long_stall();
    test_random(10);
    drain();
    repeat (200) @(posedge clk);

    $display("covered %0d request words (exponentiation and witness rounds), %0d results",
             words_sent, words_checked);
    $display("with idle, stall and long hold-off phases on both channels");
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
`default_nettype wire
